/* rtl/core/lcdt_pkg.sv */
// Shared types, codes and constants for the LCD line and mode timing controller.
// Used by every module of the block; depends on nothing else.

package lcdt_pkg;

  // Input command codes as they arrive on the bus.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Classified command kinds carried through the command queue.
  localparam logic [1:0] KIND_NOP  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_WR   = 2'd2;
  localparam logic [1:0] KIND_RD   = 2'd3;

  // Register offsets from the base of the display register window.
  localparam logic [3:0] OFF_CTRL = 4'd0;
  localparam logic [3:0] OFF_STAT = 4'd1;
  localparam logic [3:0] OFF_SCY  = 4'd2;
  localparam logic [3:0] OFF_SCX  = 4'd3;
  localparam logic [3:0] OFF_LY   = 4'd4;
  localparam logic [3:0] OFF_LYC  = 4'd5;
  localparam logic [3:0] OFF_DMA  = 4'd6;
  localparam logic [3:0] OFF_BGP  = 4'd7;
  localparam logic [3:0] OFF_OBP0 = 4'd8;
  localparam logic [3:0] OFF_OBP1 = 4'd9;
  localparam logic [3:0] OFF_WY   = 4'd10;
  localparam logic [3:0] OFF_WX   = 4'd11;

  // Register select after decode.
  localparam logic [2:0] SEL_NONE = 3'd0;
  localparam logic [2:0] SEL_CTRL = 3'd1;
  localparam logic [2:0] SEL_STAT = 3'd2;
  localparam logic [2:0] SEL_LY   = 3'd3;
  localparam logic [2:0] SEL_LYC  = 3'd4;
  localparam logic [2:0] SEL_MISC = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LINE_PERIOD    = 3'd0;
  localparam logic [2:0] CFG_FIRST_BLANK    = 3'd1;
  localparam logic [2:0] CFG_LINES_PER_FRM  = 3'd2;
  localparam logic [2:0] CFG_OAM_START      = 3'd3;
  localparam logic [2:0] CFG_XFER_START     = 3'd4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Configuration reset values.
  localparam logic [9:0] LINE_PERIOD_RST   = 10'd456;
  localparam logic [7:0] FIRST_BLANK_RST   = 8'd144;
  localparam logic [7:0] LINES_PER_FRM_RST = 8'd154;
  localparam logic [9:0] OAM_START_RST     = 10'd204;
  localparam logic [9:0] XFER_START_RST    = 10'd284;

  // Display modes.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Control and status bit positions.
  localparam int unsigned CTRL_ENABLE_BIT = 7;
  localparam int unsigned STAT_COINC      = 2;
  localparam int unsigned STAT_IE_HBLANK  = 3;
  localparam int unsigned STAT_IE_VBLANK  = 4;
  localparam int unsigned STAT_IE_OAM     = 5;
  localparam int unsigned STAT_IE_COINC   = 6;

  localparam logic [7:0] UNUSED_READ = 8'hFF;
  localparam logic [9:0] CYCLE_MAX   = 10'h3FF;

  // Misc register file and queue sizing.
  localparam int unsigned MISC_DEPTH = 8;
  localparam int unsigned MISC_IDX_W = $clog2(MISC_DEPTH);
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  // Classified command handed from the front end to the execute stage.
  typedef struct packed {
    logic [1:0]            kind;
    logic [2:0]            sel;
    logic [MISC_IDX_W-1:0] slot;
    logic [7:0]            data;
    logic [7:0]            dt;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_line_valid;
    logic [7:0] draw_line_number;
    logic       frame_done;
    logic [1:0] current_mode;
  } res_t;

endpackage

/* rtl/core/lcdt_front.sv */
// Front end: accepts input requests, decodes command and register offset,
// and holds them in a two-entry command queue. Depends on lcdt_pkg.

module lcdt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [1:0]       in_cmd,
  input  logic [3:0]       in_reg_offset,
  input  logic [7:0]       in_write_data,
  input  logic [7:0]       in_tick_cycles,
  output logic             in_full,
  output logic             head_valid,
  output lcdt_pkg::cmd_t   head,
  input  logic             head_pop
);

  lcdt_pkg::cmd_t                   q_r [lcdt_pkg::QDEPTH];
  logic [lcdt_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [lcdt_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [lcdt_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  lcdt_pkg::cmd_t                   dec;
  logic [3:0]                       slot_full;
  logic                             push_ok;
  logic                             pop_ok;

  // Classify the command and resolve the register offset.
  always_comb begin
    dec      = '0;
    dec.data = in_write_data;
    dec.dt   = in_tick_cycles;
    slot_full = '0;
    case (in_cmd)
      lcdt_pkg::CMD_TICK:  dec.kind = lcdt_pkg::KIND_TICK;
      lcdt_pkg::CMD_WRITE: dec.kind = lcdt_pkg::KIND_WR;
      lcdt_pkg::CMD_READ:  dec.kind = lcdt_pkg::KIND_RD;
      default:             dec.kind = lcdt_pkg::KIND_NOP;
    endcase
    case (in_reg_offset)
      lcdt_pkg::OFF_CTRL: dec.sel = lcdt_pkg::SEL_CTRL;
      lcdt_pkg::OFF_STAT: dec.sel = lcdt_pkg::SEL_STAT;
      lcdt_pkg::OFF_LY:   dec.sel = lcdt_pkg::SEL_LY;
      lcdt_pkg::OFF_LYC:  dec.sel = lcdt_pkg::SEL_LYC;
      lcdt_pkg::OFF_SCY, lcdt_pkg::OFF_SCX: begin
        dec.sel   = lcdt_pkg::SEL_MISC;
        slot_full = in_reg_offset - lcdt_pkg::OFF_SCY;
      end
      lcdt_pkg::OFF_DMA, lcdt_pkg::OFF_BGP, lcdt_pkg::OFF_OBP0,
      lcdt_pkg::OFF_OBP1, lcdt_pkg::OFF_WY, lcdt_pkg::OFF_WX: begin
        // Misc slots continue after the two scroll registers.
        dec.sel   = lcdt_pkg::SEL_MISC;
        slot_full = in_reg_offset - (lcdt_pkg::OFF_DMA - 4'd2);
      end
      default: dec.sel = lcdt_pkg::SEL_NONE;
    endcase
    dec.slot = slot_full[lcdt_pkg::MISC_IDX_W-1:0];
  end

  // Queue control.
  assign in_full    = (cnt_r == lcdt_pkg::QCNT_W'(lcdt_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

/* rtl/core/lcdt_back.sv */
// Back end: holds configuration and display registers, executes one queued
// command per cycle while the result queue has room and places its result
// in a two-entry result queue. Depends on lcdt_pkg.

module lcdt_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            head_valid,
  input  lcdt_pkg::cmd_t                  head,
  output logic                            head_pop,
  input  logic                            out_pop,
  output logic                            out_empty,
  output lcdt_pkg::res_t                  out_res
);

  // Configuration registers.
  logic [9:0] line_period_r;
  logic [7:0] first_blank_r;
  logic [7:0] lines_per_frm_r;
  logic [9:0] oam_start_r;
  logic [9:0] xfer_start_r;

  // Display state.
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] stat_r, stat_nxt;
  logic [7:0] ly_r, ly_nxt;
  logic [7:0] lyc_r, lyc_nxt;
  logic [7:0] misc_r [lcdt_pkg::MISC_DEPTH];
  logic [7:0] misc_nxt [lcdt_pkg::MISC_DEPTH];
  logic [9:0] cyc_r, cyc_nxt;
  logic [1:0] phase_r, phase_nxt;

  // Tick arithmetic.
  logic [10:0] cyc_sum;
  logic [10:0] cyc_left;
  logic [9:0]  cyc_sat;
  logic        line_adv;
  logic [7:0]  ly_inc;

  lcdt_pkg::res_t res;

  // Result queue.
  lcdt_pkg::res_t                 rq_r [lcdt_pkg::QDEPTH];
  logic [lcdt_pkg::QPTR_W-1:0]    rq_wr_r, rq_wr_nxt;
  logic [lcdt_pkg::QPTR_W-1:0]    rq_rd_r, rq_rd_nxt;
  logic [lcdt_pkg::QCNT_W-1:0]    rq_cnt_r, rq_cnt_nxt;
  logic                           rq_full;
  logic                           step;
  logic                           rq_pop_ok;

  assign rq_full  = (rq_cnt_r == lcdt_pkg::QCNT_W'(lcdt_pkg::QDEPTH));
  assign step     = head_valid && !rq_full;
  assign head_pop = step;

  // Cycle accumulation, line advance and saturation.
  assign cyc_sum  = {1'b0, cyc_r} + {3'b000, head.dt};
  assign line_adv = (cyc_sum >= {1'b0, line_period_r});
  assign cyc_left = line_adv ? (cyc_sum - {1'b0, line_period_r}) : cyc_sum;
  assign cyc_sat  = (cyc_left > {1'b0, lcdt_pkg::CYCLE_MAX}) ? lcdt_pkg::CYCLE_MAX
                                                             : cyc_left[9:0];
  assign ly_inc   = ly_r + 8'd1;

  // Execute the command at the head of the queue. The mode bits of the
  // status register follow the phase only when the phase is set, so a
  // written value stays until the phase is next set.
  always_comb begin
    ctrl_nxt  = ctrl_r;
    stat_nxt  = stat_r;
    ly_nxt    = ly_r;
    lyc_nxt   = lyc_r;
    misc_nxt  = misc_r;
    cyc_nxt   = cyc_r;
    phase_nxt = phase_r;
    res       = '0;
    case (head.kind)
      lcdt_pkg::KIND_WR: begin
        case (head.sel)
          lcdt_pkg::SEL_CTRL: ctrl_nxt = head.data;
          lcdt_pkg::SEL_STAT: stat_nxt = head.data;
          lcdt_pkg::SEL_LY:   ly_nxt   = head.data;
          lcdt_pkg::SEL_LYC:  lyc_nxt  = head.data;
          lcdt_pkg::SEL_MISC: misc_nxt[head.slot] = head.data;
          default: ;
        endcase
      end
      lcdt_pkg::KIND_RD: begin
        case (head.sel)
          lcdt_pkg::SEL_CTRL: res.read_data = ctrl_r;
          lcdt_pkg::SEL_STAT: res.read_data = stat_r;
          lcdt_pkg::SEL_LY:   res.read_data = ly_r;
          lcdt_pkg::SEL_LYC:  res.read_data = lyc_r;
          lcdt_pkg::SEL_MISC: res.read_data = misc_r[head.slot];
          default:            res.read_data = lcdt_pkg::UNUSED_READ;
        endcase
      end
      lcdt_pkg::KIND_TICK: begin
        if (ctrl_r[lcdt_pkg::CTRL_ENABLE_BIT]) begin
          if (line_adv) begin
            ly_nxt = ly_inc;
            // Coincidence uses the incremented count before the frame wrap.
            if (ly_inc == lyc_r) begin
              stat_nxt[lcdt_pkg::STAT_COINC] = 1'b1;
              if (stat_r[lcdt_pkg::STAT_IE_COINC]) begin
                res.stat_irq = 1'b1;
              end
            end else begin
              stat_nxt[lcdt_pkg::STAT_COINC] = 1'b0;
            end
            if (ly_inc < first_blank_r) begin
              res.draw_line_valid  = 1'b1;
              res.draw_line_number = ly_r;
              phase_nxt            = lcdt_pkg::MODE_HBLANK;
              stat_nxt[1:0]        = lcdt_pkg::MODE_HBLANK;
              if (stat_r[lcdt_pkg::STAT_IE_HBLANK]) begin
                res.stat_irq = 1'b1;
              end
            end else if (ly_inc == first_blank_r) begin
              res.draw_line_valid  = 1'b1;
              res.draw_line_number = ly_r;
              res.vblank_irq       = 1'b1;
              res.frame_done       = 1'b1;
              phase_nxt            = lcdt_pkg::MODE_VBLANK;
              stat_nxt[1:0]        = lcdt_pkg::MODE_VBLANK;
              if (stat_r[lcdt_pkg::STAT_IE_VBLANK]) begin
                res.stat_irq = 1'b1;
              end
            end else if (ly_inc >= lines_per_frm_r) begin
              ly_nxt        = ly_inc - lines_per_frm_r;
              phase_nxt     = lcdt_pkg::MODE_HBLANK;
              stat_nxt[1:0] = lcdt_pkg::MODE_HBLANK;
              if (stat_r[lcdt_pkg::STAT_IE_HBLANK]) begin
                res.stat_irq = 1'b1;
              end
            end
          end
          cyc_nxt = cyc_sat;
          // Phase steps inside a visible line.
          if (phase_nxt != lcdt_pkg::MODE_VBLANK) begin
            if ((cyc_sat >= xfer_start_r) && (phase_nxt == lcdt_pkg::MODE_OAM)) begin
              phase_nxt     = lcdt_pkg::MODE_XFER;
              stat_nxt[1:0] = lcdt_pkg::MODE_XFER;
            end else if ((cyc_sat >= oam_start_r) &&
                         (phase_nxt == lcdt_pkg::MODE_HBLANK)) begin
              phase_nxt     = lcdt_pkg::MODE_OAM;
              stat_nxt[1:0] = lcdt_pkg::MODE_OAM;
              if (stat_r[lcdt_pkg::STAT_IE_OAM]) begin
                res.stat_irq = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.current_mode = phase_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_period_r   <= lcdt_pkg::LINE_PERIOD_RST;
      first_blank_r   <= lcdt_pkg::FIRST_BLANK_RST;
      lines_per_frm_r <= lcdt_pkg::LINES_PER_FRM_RST;
      oam_start_r     <= lcdt_pkg::OAM_START_RST;
      xfer_start_r    <= lcdt_pkg::XFER_START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdt_pkg::CFG_LINE_PERIOD:   line_period_r   <= cfg_wdata;
        lcdt_pkg::CFG_FIRST_BLANK:   first_blank_r   <= cfg_wdata[7:0];
        lcdt_pkg::CFG_LINES_PER_FRM: lines_per_frm_r <= cfg_wdata[7:0];
        lcdt_pkg::CFG_OAM_START:     oam_start_r     <= cfg_wdata;
        lcdt_pkg::CFG_XFER_START:    xfer_start_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Display state update, one command per step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      stat_r  <= '0;
      ly_r    <= '0;
      lyc_r   <= '0;
      cyc_r   <= '0;
      phase_r <= lcdt_pkg::MODE_HBLANK;
      for (int i = 0; i < lcdt_pkg::MISC_DEPTH; i++) begin
        misc_r[i] <= '0;
      end
    end else if (step) begin
      ctrl_r  <= ctrl_nxt;
      stat_r  <= stat_nxt;
      ly_r    <= ly_nxt;
      lyc_r   <= lyc_nxt;
      cyc_r   <= cyc_nxt;
      phase_r <= phase_nxt;
      misc_r  <= misc_nxt;
    end
  end

  // Result queue control.
  assign out_empty = (rq_cnt_r == '0);
  assign out_res   = rq_r[rq_rd_r];
  assign rq_pop_ok = out_pop && !out_empty;

  always_comb begin
    rq_wr_nxt  = rq_wr_r;
    rq_rd_nxt  = rq_rd_r;
    rq_cnt_nxt = rq_cnt_r;
    if (step) begin
      rq_wr_nxt = rq_wr_r + 1'b1;
    end
    if (rq_pop_ok) begin
      rq_rd_nxt = rq_rd_r + 1'b1;
    end
    if (step && !rq_pop_ok) begin
      rq_cnt_nxt = rq_cnt_r + 1'b1;
    end else if (rq_pop_ok && !step) begin
      rq_cnt_nxt = rq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      rq_wr_r  <= rq_wr_nxt;
      rq_rd_r  <= rq_rd_nxt;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rq_r[rq_wr_r] <= res;
    end
  end

endmodule

/* rtl/core/lcd_line_mode_timing_controller.sv */
// Path: a pushed request is decoded into the command queue, executed from
// its head and registered into the result queue, which drives the result
// ports. Throughput: one request per cycle while the result queue has room.
// Reset: synchronous active-low rst_n empties both queues, clears the display
// registers and loads the configuration defaults.
// Top level; depends on lcdt_pkg, lcdt_front and lcdt_back.

module lcd_line_mode_timing_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [1:0]                      in_cmd,
  input  logic [3:0]                      in_reg_offset,
  input  logic [7:0]                      in_write_data,
  input  logic [7:0]                      in_tick_cycles,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [7:0]                      out_read_data,
  output logic                            out_vblank_irq,
  output logic                            out_stat_irq,
  output logic                            out_draw_line_valid,
  output logic [7:0]                      out_draw_line_number,
  output logic                            out_frame_done,
  output logic [1:0]                      out_current_mode,
  input  logic                            cfg_we,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic           head_valid;
  logic           head_pop;
  lcdt_pkg::cmd_t head;
  lcdt_pkg::res_t out_res;

  // Decode and command queue.
  lcdt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_cmd         (in_cmd),
    .in_reg_offset  (in_reg_offset),
    .in_write_data  (in_write_data),
    .in_tick_cycles (in_tick_cycles),
    .in_full        (in_full),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop)
  );

  // Execute and result queue.
  lcdt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_res    (out_res)
  );

  // Unpack the result item onto its ports.
  assign out_read_data        = out_res.read_data;
  assign out_vblank_irq       = out_res.vblank_irq;
  assign out_stat_irq         = out_res.stat_irq;
  assign out_draw_line_valid  = out_res.draw_line_valid;
  assign out_draw_line_number = out_res.draw_line_number;
  assign out_frame_done       = out_res.frame_done;
  assign out_current_mode     = out_res.current_mode;

endmodule

/* rtl/core/lcdt_checker.sv */
// Port-level checks for the LCD line and mode timing controller, bound to
// the top level. Depends on lcdt_pkg and lcd_line_mode_timing_controller.

module lcdt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_read_data,
  input logic       out_vblank_irq,
  input logic       out_draw_line_valid,
  input logic [7:0] out_draw_line_number,
  input logic       out_frame_done,
  input logic [1:0] out_current_mode
);

  logic [2:0] pend_r, pend_nxt;
  logic       acc_in;
  logic       acc_out;

  // Count requests accepted but not yet delivered.
  assign acc_in  = in_push && !in_full;
  assign acc_out = out_pop && !out_empty;

  always_comb begin
    pend_nxt = pend_r;
    if (acc_in && !acc_out) begin
      pend_nxt = pend_r + 3'd1;
    end else if (acc_out && !acc_in) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // No result appears without an outstanding request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 3'd0) |-> out_empty)
    else $error("result shown with no request outstanding");

  // Reset leaves the result side empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  // A waiting result keeps its read data and mode until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_read_data)
                                  && $stable(out_current_mode)))
    else $error("waiting result changed before it was taken");

  // Frame end comes with a VBlank interrupt, a draw request and VBlank mode.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_done) |-> (out_vblank_irq && out_draw_line_valid
                                        && out_current_mode == lcdt_pkg::MODE_VBLANK))
    else $error("frame end without VBlank indications");

  // Line number is only given with a draw request.
  a_draw_number: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_draw_line_valid) |-> (out_draw_line_number == 8'd0))
    else $error("draw line number set without a draw request");

endmodule

bind lcd_line_mode_timing_controller lcdt_checker u_lcdt_checker (.*);

/* bench/lcdt_timing_checker.sv */
// Checker for the LCD line and mode timing controller: watches the request,
// result and configuration ports, predicts every result and compares it.
// Depends on lcdt_pkg for the command, offset, mode and result definitions.

module lcdt_timing_checker
  import lcdt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_full,
  input  logic [1:0]             in_cmd,
  input  logic [3:0]             in_reg_offset,
  input  logic [7:0]             in_write_data,
  input  logic [7:0]             in_tick_cycles,
  input  logic                   out_empty,
  input  logic                   out_pop,
  input  logic [7:0]             out_read_data,
  input  logic                   out_vblank_irq,
  input  logic                   out_stat_irq,
  input  logic                   out_draw_line_valid,
  input  logic [7:0]             out_draw_line_number,
  input  logic                   out_frame_done,
  input  logic [1:0]             out_current_mode,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     outstanding,
  output int                     results_seen,
  output int                     frames_seen,
  output int                     stat_irqs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration.
  logic [9:0] cf_line_len;
  logic [7:0] cf_vblank_line;
  logic [7:0] cf_frame_lines;
  logic [9:0] cf_oam_at;
  logic [9:0] cf_xfer_at;

  // Shadow copy of the display registers and the line timing state.
  logic [7:0] disp_ctrl;
  logic [7:0] disp_stat;
  logic [7:0] line_no;
  logic [7:0] line_match;
  logic [7:0] aux_regs [MISC_DEPTH];
  logic [9:0] dot_count;
  logic [1:0] cur_mode;

  // Results predicted for accepted requests, oldest first.
  res_t pending_results [$];

  // The scroll pair sits below the line counter, the rest of the plain
  // registers above the compare register.
  function automatic int aux_slot(input logic [3:0] off);
    return (off < OFF_LY) ? int'(off - OFF_SCY) : int'(off - OFF_LY);
  endfunction

  // The mode is mirrored in the low two bits of the status register.
  function automatic void enter_mode(input logic [1:0] m);
    cur_mode = m;
    disp_stat[1:0] = m;
  endfunction

  // Applies one request to the shadow state and returns its result.
  task automatic step_display(input logic [1:0] cmd, input logic [3:0] off,
                              input logic [7:0] wd, input logic [7:0] dt,
                              output res_t r);
    int acc;
    r = '0;
    case (cmd)
      CMD_WRITE: begin
        case (off)
          OFF_CTRL: disp_ctrl = wd;
          OFF_STAT: disp_stat = wd;
          OFF_LY:   line_no = wd;
          OFF_LYC:  line_match = wd;
          OFF_SCY, OFF_SCX, OFF_DMA, OFF_BGP, OFF_OBP0, OFF_OBP1, OFF_WY, OFF_WX:
            aux_regs[aux_slot(off)] = wd;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (off)
          OFF_CTRL: r.read_data = disp_ctrl;
          OFF_STAT: r.read_data = disp_stat;
          OFF_LY:   r.read_data = line_no;
          OFF_LYC:  r.read_data = line_match;
          OFF_SCY, OFF_SCX, OFF_DMA, OFF_BGP, OFF_OBP0, OFF_OBP1, OFF_WY, OFF_WX:
            r.read_data = aux_regs[aux_slot(off)];
          default:  r.read_data = UNUSED_READ;
        endcase
      end
      CMD_TICK: begin
        if (disp_ctrl[CTRL_ENABLE_BIT]) begin
          acc = int'(dot_count) + int'(dt);
          // At most one line advances per tick.
          if (acc >= int'(cf_line_len)) begin
            acc -= int'(cf_line_len);
            line_no = line_no + 8'd1;
            // Coincidence uses the new count before any frame wrap.
            if (line_no == line_match) begin
              disp_stat[STAT_COINC] = 1'b1;
              if (disp_stat[STAT_IE_COINC]) r.stat_irq = 1'b1;
            end else begin
              disp_stat[STAT_COINC] = 1'b0;
            end
            if (line_no < cf_vblank_line) begin
              r.draw_line_valid = 1'b1;
              r.draw_line_number = line_no - 8'd1;
              enter_mode(MODE_HBLANK);
              if (disp_stat[STAT_IE_HBLANK]) r.stat_irq = 1'b1;
            end else if (line_no == cf_vblank_line) begin
              r.draw_line_valid = 1'b1;
              r.draw_line_number = line_no - 8'd1;
              enter_mode(MODE_VBLANK);
              r.vblank_irq = 1'b1;
              r.frame_done = 1'b1;
              if (disp_stat[STAT_IE_VBLANK]) r.stat_irq = 1'b1;
            end else if (line_no >= cf_frame_lines) begin
              line_no = line_no - cf_frame_lines;
              enter_mode(MODE_HBLANK);
              if (disp_stat[STAT_IE_HBLANK]) r.stat_irq = 1'b1;
            end
          end
          if (acc > int'(CYCLE_MAX)) acc = int'(CYCLE_MAX);
          dot_count = 10'(acc);
          // Mode steps inside the line, never out of vertical blank.
          if (cur_mode != MODE_VBLANK) begin
            if (dot_count >= cf_xfer_at && cur_mode == MODE_OAM) begin
              enter_mode(MODE_XFER);
            end else if (dot_count >= cf_oam_at && cur_mode == MODE_HBLANK) begin
              enter_mode(MODE_OAM);
              if (disp_stat[STAT_IE_OAM]) r.stat_irq = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.current_mode = cur_mode;
  endtask

  // Everything is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      cf_line_len = LINE_PERIOD_RST;
      cf_vblank_line = FIRST_BLANK_RST;
      cf_frame_lines = LINES_PER_FRM_RST;
      cf_oam_at = OAM_START_RST;
      cf_xfer_at = XFER_START_RST;
      disp_ctrl = '0;
      disp_stat = '0;
      line_no = '0;
      line_match = '0;
      foreach (aux_regs[i]) aux_regs[i] = '0;
      dot_count = '0;
      cur_mode = MODE_HBLANK;
      pending_results.delete();
      mismatches = 0;
      results_seen = 0;
      frames_seen = 0;
      stat_irqs_seen = 0;
    end else begin
      // Configuration writes take effect at the edge they are sampled.
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_PERIOD:   cf_line_len = cfg_wdata;
          CFG_FIRST_BLANK:   cf_vblank_line = cfg_wdata[7:0];
          CFG_LINES_PER_FRM: cf_frame_lines = cfg_wdata[7:0];
          CFG_OAM_START:     cf_oam_at = cfg_wdata;
          CFG_XFER_START:    cf_xfer_at = cfg_wdata;
          default: ;
        endcase
      end

      // Compare a popped result with the oldest prediction.
      if (out_pop && !out_empty) begin
        got = {out_read_data, out_vblank_irq, out_stat_irq, out_draw_line_valid,
               out_draw_line_number, out_frame_done, out_current_mode};
        results_seen++;
        if (got.frame_done) frames_seen++;
        if (got.stat_irq) stat_irqs_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result popped with no request outstanding", $time);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch want rd=%h vb=%b st=%b dv=%b dn=%h fd=%b md=%0d",
                       $time, want.read_data, want.vblank_irq, want.stat_irq,
                       want.draw_line_valid, want.draw_line_number,
                       want.frame_done, want.current_mode);
              $display("%0t:          got  rd=%h vb=%b st=%b dv=%b dn=%h fd=%b md=%0d",
                       $time, got.read_data, got.vblank_irq, got.stat_irq,
                       got.draw_line_valid, got.draw_line_number,
                       got.frame_done, got.current_mode);
            end
            mismatches++;
          end
        end
      end

      // Predict the result of an accepted request.
      if (in_push && !in_full) begin
        step_display(in_cmd, in_reg_offset, in_write_data, in_tick_cycles, want);
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

/* bench/tb_lcd_line_mode_timing_controller.sv */
// Testbench top for the LCD line and mode timing controller: makes requests,
// configuration writes and pops, and reports the verdict.
// Depends on lcdt_pkg, the controller RTL and lcdt_timing_checker.

module tb_lcd_line_mode_timing_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdt_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam logic [3:0] OFF_UNUSED_LO = 4'd12;
  localparam logic [3:0] OFF_UNUSED_HI = 4'd15;
  localparam int RANDOM_PER_SETTING = 170;
  localparam int SETTING_COUNT      = 6;
  localparam int HOLDOFF_CYCLES     = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [1:0]            in_cmd = CMD_TICK;
  logic [3:0]            in_reg_offset = OFF_CTRL;
  logic [7:0]            in_write_data = '0;
  logic [7:0]            in_tick_cycles = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [7:0]            out_read_data;
  logic                  out_vblank_irq;
  logic                  out_stat_irq;
  logic                  out_draw_line_valid;
  logic [7:0]            out_draw_line_number;
  logic                  out_frame_done;
  logic [1:0]            out_current_mode;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LINE_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int results_seen;
  int frames_seen;
  int stat_irqs_seen;
  int requests_sent = 0;
  bit hold_req = 1'b0;

  lcd_line_mode_timing_controller dut (.*);

  lcdt_timing_checker checker_i (.*);

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offers one request and returns at the edge that accepts it, leaving
  // push high so that a burst can continue without a gap.
  task automatic send_request(input logic [1:0] cmd, input logic [3:0] off,
                              input logic [7:0] wd, input logic [7:0] dt);
    in_push <= 1'b1;
    in_cmd <= cmd;
    in_reg_offset <= off;
    in_write_data <= wd;
    in_tick_cycles <= dt;
    do @(posedge clk); while (in_full);
    requests_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    in_push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending until every predicted result has been popped.
  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes all five timing registers back to back; the block is idle here.
  task automatic load_settings(input logic [9:0] setting [5]);
    logic [CFG_IDX_W-1:0] idx_list [5];
    idx_list = '{CFG_LINE_PERIOD, CFG_FIRST_BLANK, CFG_LINES_PER_FRM,
                 CFG_OAM_START, CFG_XFER_START};
    cfg_we <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx_list[i];
      cfg_wdata <= setting[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ticks, with register traffic and the odd unused command. Display
  // enable is kept on in most control writes so the timing keeps running.
  task automatic send_random_request();
    int pick;
    logic [1:0] cmd;
    logic [3:0] off;
    logic [7:0] wd;
    logic [7:0] dt;
    pick = $urandom_range(0, 99);
    off = 4'($urandom_range(0, 15));
    wd = 8'($urandom);
    dt = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
    if (pick < 58) begin
      cmd = CMD_TICK;
    end else if (pick < 74) begin
      cmd = CMD_WRITE;
      if (off == OFF_CTRL && $urandom_range(0, 9) != 0) wd[CTRL_ENABLE_BIT] = 1'b1;
      if ((off == OFF_LYC || off == OFF_LY) && $urandom_range(0, 1) == 0)
        wd = 8'($urandom_range(0, 15));
    end else if (pick < 95) begin
      cmd = CMD_READ;
    end else begin
      cmd = CMD_UNUSED;
    end
    send_request(cmd, off, wd, dt);
  endtask

  // Receiver: pops on a rotating pattern that is redrawn now and then, and
  // holds off completely for a long stretch when asked.
  initial begin
    logic [15:0] pop_pat;
    int pat_age;
    int hold_left;
    pop_pat = '1;
    pat_age = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLDOFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        if (pat_age == 0) begin
          pat_age = $urandom_range(16, 80);
          case ($urandom_range(0, 3))
            0:       pop_pat = '1;
            1:       pop_pat = 16'($urandom);
            default: pop_pat = 16'($urandom | $urandom);
          endcase
          pop_pat[0] = 1'b1;
        end
        pat_age--;
        out_pop <= pop_pat[0];
        pop_pat = {pop_pat[0], pop_pat[15:1]};
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [9:0] setting [5];
    int burst_left;
    bit steady;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset configuration: unused offsets, plain
    // registers, a coincidence, the start of vertical blank, the frame wrap,
    // an unknown command and a tick with the display off.
    send_request(CMD_READ, OFF_UNUSED_HI, 8'h00, 8'h00);
    send_request(CMD_WRITE, OFF_UNUSED_LO, 8'hFF, 8'hFF);
    send_request(CMD_READ, OFF_UNUSED_LO, 8'h00, 8'h00);
    send_request(CMD_WRITE, OFF_CTRL, 8'hFF, 8'h00);
    send_request(CMD_READ, OFF_CTRL, 8'h00, 8'h00);
    send_request(CMD_WRITE, OFF_STAT, 8'h7F, 8'h00);
    send_request(CMD_READ, OFF_STAT, 8'h00, 8'h00);
    send_request(CMD_WRITE, OFF_LYC, 8'h01, 8'h00);
    send_request(CMD_WRITE, OFF_DMA, 8'hA5, 8'h00);
    send_request(CMD_READ, OFF_DMA, 8'h00, 8'h00);
    send_request(CMD_WRITE, OFF_WX, 8'h5A, 8'h00);
    send_request(CMD_READ, OFF_WX, 8'h00, 8'h00);
    send_request(CMD_TICK, OFF_CTRL, 8'h00, 8'h00);
    send_request(CMD_TICK, OFF_CTRL, 8'h00, 8'hFF);
    send_request(CMD_TICK, OFF_CTRL, 8'h00, 8'hFF);
    send_request(CMD_WRITE, OFF_LY, 8'd143, 8'h00);
    send_request(CMD_TICK, OFF_CTRL, 8'h00, 8'hFF);
    send_request(CMD_TICK, OFF_CTRL, 8'h00, 8'hFF);
    send_request(CMD_WRITE, OFF_LY, 8'd153, 8'h00);
    send_request(CMD_TICK, OFF_CTRL, 8'h00, 8'hFF);
    send_request(CMD_TICK, OFF_CTRL, 8'h00, 8'hFF);
    send_request(CMD_READ, OFF_LY, 8'h00, 8'h00);
    send_request(CMD_UNUSED, OFF_UNUSED_HI, 8'hFF, 8'hFF);
    send_request(CMD_WRITE, OFF_CTRL, 8'h00, 8'h00);
    send_request(CMD_TICK, OFF_CTRL, 8'h00, 8'hFF);
    drain_results();

    // Random traffic over several timing settings: low extremes, high
    // extremes, zero and inverted values, a small frame and random ones.
    for (int p = 0; p < SETTING_COUNT; p++) begin
      case (p)
        0: setting = '{10'd1, 10'd1, 10'd1, 10'd0, 10'd0};
        1: setting = '{10'd1023, 10'd255, 10'd255, 10'd1023, 10'd1023};
        2: setting = '{10'd0, 10'd0, 10'd0, 10'd5, 10'd3};
        3: setting = '{10'd40, 10'd10, 10'd14, 10'd12, 10'd22};
        default: begin
          setting[0] = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1, 1023))
                                                   : 10'($urandom_range(1, 64));
          setting[1] = 10'($urandom_range(1, 24));
          setting[2] = 10'($urandom_range(1, 28));
          setting[3] = 10'($urandom_range(0, setting[0]));
          setting[4] = 10'($urandom_range(0, setting[0]));
        end
      endcase
      load_settings(setting);
      steady = (p == 1) || ($urandom_range(0, 3) == 0);
      send_request(CMD_WRITE, OFF_CTRL, 8'h80 | 8'($urandom_range(0, 127)), 8'h00);
      // Stall the receiver while requests keep coming, to fill the block.
      if (p == 1) hold_req = 1'b1;
      burst_left = 0;
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!steady) pause_sender($urandom_range(1, 6));
        end
        if (p == 3 && n == RANDOM_PER_SETTING / 2) drain_results();
        send_random_request();
        burst_left--;
      end
      drain_results();
    end

    $display("summary: %0d requests over %0d timing settings, %0d results checked",
             requests_sent, SETTING_COUNT + 1, results_seen);
    $display("summary: %0d frame ends and %0d status interrupts observed",
             frames_seen, stat_irqs_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
rtl/core/lcdt_pkg.sv
rtl/core/lcdt_front.sv
rtl/core/lcdt_back.sv
rtl/core/lcd_line_mode_timing_controller.sv
rtl/core/lcdt_checker.sv
bench/lcdt_timing_checker.sv
bench/tb_lcd_line_mode_timing_controller.sv
